FILE: rtl/blg_pkg.sv
`default_nettype none

package blg_pkg;

  // Width of every coordinate field on the ports.
  localparam int unsigned COORD_W = 6;

  // Number of low coordinate bits that take part in the walk.
  localparam int unsigned COORD_BITS_DEF = 6;

  localparam int unsigned COLOR_W = 32;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] line_color;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the input word
    logic setup;  // derive walk registers from the captured word
    logic emit;   // write the current pixel to the output register and step
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end; // the current pixel is the last one of the line
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/blg_datapath.sv
`default_nettype none

module blg_datapath #(
  parameter int unsigned COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
  input  wire                  clk_i,
  input  blg_pkg::in_word_t    in_word_i,
  input  blg_pkg::ctrl_cmd_t   cmd_i,
  output blg_pkg::dp_status_t  status_o,
  output blg_pkg::out_word_t   out_word_o
);

  localparam int unsigned C  = COORD_BITS;
  // The error stays within (-dx, 3*dx], which needs two bits above a coordinate plus sign.
  localparam int unsigned EW = COORD_BITS + 3;
  localparam int unsigned FW = blg_pkg::COORD_W;

  blg_pkg::in_word_t  cmd_q;
  blg_pkg::out_word_t out_q;

  logic                 steep_q;
  logic                 neg_q;
  logic [C-1:0]         major_q;
  logic [C-1:0]         end_q;
  logic [C-1:0]         minor_q;
  logic [C-1:0]         dx_q;
  logic [C-1:0]         ady_q;
  logic signed [EW-1:0] err_q;

  // Setup terms.
  logic [C-1:0] ax, ay, bx, by;
  logic [C-1:0] adx_raw, ady_raw;
  logic         steep_s;
  logic [C-1:0] a_maj, a_min, b_maj, b_min;
  logic         swap_s;
  logic [C-1:0] maj0, min0, maj1, min1;
  logic [C-1:0] dx_s, ady_s;
  logic         neg_s;

  // Walk terms.
  logic signed [EW-1:0] ady2, dx_e, dx2, err_sum;
  logic                 err_over;
  logic [C-1:0]         minor_step;
  logic [C-1:0]         px, py;

  always_comb begin
    ax = cmd_q.x_start[C-1:0];
    ay = cmd_q.y_start[C-1:0];
    bx = cmd_q.x_end[C-1:0];
    by = cmd_q.y_end[C-1:0];

    adx_raw = (ax >= bx) ? (ax - bx) : (bx - ax);
    ady_raw = (ay >= by) ? (ay - by) : (by - ay);
    steep_s = adx_raw < ady_raw;

    a_maj = steep_s ? ay : ax;
    a_min = steep_s ? ax : ay;
    b_maj = steep_s ? by : bx;
    b_min = steep_s ? bx : by;

    // Walk from the smaller major coordinate to the larger one.
    swap_s = a_maj > b_maj;
    maj0   = swap_s ? b_maj : a_maj;
    min0   = swap_s ? b_min : a_min;
    maj1   = swap_s ? a_maj : b_maj;
    min1   = swap_s ? a_min : b_min;

    dx_s  = maj1 - maj0;
    ady_s = (min1 >= min0) ? (min1 - min0) : (min0 - min1);
    neg_s = !(min1 > min0);
  end

  always_comb begin
    ady2     = $signed(EW'({ady_q, 1'b0}));
    dx_e     = $signed(EW'(dx_q));
    dx2      = $signed(EW'({dx_q, 1'b0}));
    err_sum  = err_q + ady2;
    err_over = err_sum > dx_e;
    minor_step = neg_q ? (minor_q - C'(1)) : (minor_q + C'(1));
    px = steep_q ? minor_q : major_q;
    py = steep_q ? major_q : minor_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_word_i;
    end
    if (cmd_i.setup) begin
      steep_q <= steep_s;
      neg_q   <= neg_s;
      major_q <= maj0;
      end_q   <= maj1;
      minor_q <= min0;
      dx_q    <= dx_s;
      ady_q   <= ady_s;
      err_q   <= '0;
    end else if (cmd_i.emit) begin
      out_q.pixel_x     <= FW'(px);
      out_q.pixel_y     <= FW'(py);
      out_q.pixel_color <= cmd_q.line_color;
      out_q.last_pixel  <= (major_q == end_q);
      major_q <= major_q + C'(1);
      if (err_over) begin
        minor_q <= minor_step;
        err_q   <= err_sum - dx2;
      end else begin
        err_q   <= err_sum;
      end
    end
  end

  assign status_o.at_end = (major_q == end_q);
  assign out_word_o      = out_q;

endmodule

`default_nettype wire

FILE: rtl/blg_controller.sv
`default_nettype none

module blg_controller (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  blg_pkg::dp_status_t  status_i,
  output blg_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    // The output register can take a new word when empty or being drained.
    slot_free   = !out_valid_q || out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.at_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // A pending word is never overwritten by the next pixel.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit && out_valid_q && !out_ready_i))
    else $error("pixel written over an untaken word");

  // An accepted command always goes through setup next.
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SETUP))
    else $error("accepted command skipped setup");

  // Writing the final pixel ends the line.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && status_i.at_end) |=> (state_q == ST_IDLE))
    else $error("walk continued past the final pixel");

  // Every emitted pixel shows up as a valid word in the next cycle.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_o)
    else $error("emitted pixel not presented");
`endif

endmodule

`default_nettype wire

FILE: rtl/bresenham_line_generator.sv
// Channel | Direction | Handshake                  | Word
// input   | in        | in_valid_i / in_ready_o    | in_word_i  (endpoints, color)
// output  | out       | out_valid_o / out_ready_i  | out_word_o (pixel, color, last)
//
// After a command is accepted, a setup state derives the walk from the captured command;
// the walk then writes one pixel per cycle into the output register while that register
// is free or being drained, from the error update and major-axis counter.
// The next command is taken in the cycle after the last pixel is written.
// Reset clears only the state machine and the output valid flag.
// A stalled output holds the walk in place until the pending word is taken.
`default_nettype none

module bresenham_line_generator #(
  parameter int unsigned COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  blg_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output blg_pkg::out_word_t  out_word_o
);

  blg_pkg::ctrl_cmd_t  cmd;
  blg_pkg::dp_status_t status;

  blg_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  blg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire
